/* src/rvx_pkg.sv */
package rvx_pkg;

  // Data memory geometry: cells are indexed by the low address bits,
  // so the depth is a power of two and at least 32 (the reset sweep
  // also clears the register file through the low five index bits).
  localparam int MEM_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int XLEN   = 32;
  localparam int REG_W  = 5;
  localparam int OP_W   = 6;
  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 120;

  typedef enum logic [OP_W-1:0] {
    OP_LUI   = 6'd0,
    OP_AUIPC = 6'd1,
    OP_JAL   = 6'd2,
    OP_JALR  = 6'd3,
    OP_BEQ   = 6'd4,
    OP_BNE   = 6'd5,
    OP_BLT   = 6'd6,
    OP_BGE   = 6'd7,
    OP_BLTU  = 6'd8,
    OP_BGEU  = 6'd9,
    OP_LB    = 6'd10,
    OP_LH    = 6'd11,
    OP_LW    = 6'd12,
    OP_LBU   = 6'd13,
    OP_LHU   = 6'd14,
    OP_SB    = 6'd15,
    OP_SH    = 6'd16,
    OP_SW    = 6'd17,
    OP_ADDI  = 6'd18,
    OP_SLTI  = 6'd19,
    OP_SLTIU = 6'd20,
    OP_XORI  = 6'd21,
    OP_ORI   = 6'd22,
    OP_ANDI  = 6'd23,
    OP_SLLI  = 6'd24,
    OP_SRLI  = 6'd25,
    OP_SRAI  = 6'd26,
    OP_ADD   = 6'd27,
    OP_SUB   = 6'd28,
    OP_SLL   = 6'd29,
    OP_SLT   = 6'd30,
    OP_SLTU  = 6'd31,
    OP_XOR   = 6'd32,
    OP_SRL   = 6'd33,
    OP_SRA   = 6'd34,
    OP_OR    = 6'd35,
    OP_AND   = 6'd36,
    OP_HALT  = 6'd37
  } op_t;

  // Execute stage outcome for one item.
  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              halt;
    logic              reg_wr;
    logic              is_load;
    logic [XLEN-1:0]   val;
    logic              mem_wr;
    logic [XLEN-1:0]   mem_val;
    logic [ADDR_W-1:0] ea;
  } ex_t;

  // Load data alignment: narrow loads take the low bits of the cell.
  function automatic logic [XLEN-1:0] load_ext(op_t op, logic [XLEN-1:0] d);
    logic [XLEN-1:0] r;
    case (op)
      OP_LB:   r = {{(XLEN-8){d[7]}}, d[7:0]};
      OP_LH:   r = {{(XLEN-16){d[15]}}, d[15:0]};
      OP_LBU:  r = {{(XLEN-8){1'b0}}, d[7:0]};
      OP_LHU:  r = {{(XLEN-16){1'b0}}, d[15:0]};
      default: r = d;
    endcase
    return r;
  endfunction

endpackage

/* src/rvx_regfile.sv */
module rvx_regfile (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rvx_pkg::REG_W-1:0] raddr_a,
  input  logic [rvx_pkg::REG_W-1:0] raddr_b,
  input  logic                      we,
  input  logic [rvx_pkg::REG_W-1:0] waddr,
  input  logic [rvx_pkg::XLEN-1:0]  wdata,
  output logic [rvx_pkg::XLEN-1:0]  rdata_a,
  output logic [rvx_pkg::XLEN-1:0]  rdata_b
);
  import rvx_pkg::*;

  logic [XLEN-1:0] rf [2**REG_W];

  always_ff @(posedge clk) begin
    if (we) begin
      rf[waddr] <= wdata;
    end
  end

  // Registered reads, write-through on a same-edge write.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_a <= (we && waddr == raddr_a) ? wdata : rf[raddr_a];
      rdata_b <= (we && waddr == raddr_b) ? wdata : rf[raddr_b];
    end
  end

endmodule

/* src/rvx_dmem.sv */
module rvx_dmem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [rvx_pkg::ADDR_W-1:0] waddr,
  input  logic [rvx_pkg::XLEN-1:0]   wdata,
  input  logic                       re,
  input  logic [rvx_pkg::ADDR_W-1:0] raddr,
  output logic [rvx_pkg::XLEN-1:0]   rdata
);
  import rvx_pkg::*;

  logic [XLEN-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/rvx_exec.sv */
module rvx_exec (
  input  rvx_pkg::op_t              op,
  input  logic [rvx_pkg::REG_W-1:0] rd,
  input  logic [rvx_pkg::XLEN-1:0]  a,
  input  logic [rvx_pkg::XLEN-1:0]  b,
  input  logic [rvx_pkg::XLEN-1:0]  imm,
  input  logic [rvx_pkg::XLEN-1:0]  pc,
  input  logic                      halted,
  output rvx_pkg::ex_t              ex
);
  import rvx_pkg::*;

  logic [XLEN-1:0] pc4;
  logic [XLEN-1:0] pci;
  logic [XLEN-1:0] sum;
  logic [4:0]      shi;
  logic [4:0]      shr;
  logic            wr;

  assign pc4 = pc + 32'd4;
  assign pci = pc + imm;
  assign sum = a + imm;
  assign shi = imm[4:0];
  assign shr = b[4:0];

  always_comb begin
    ex         = '0;
    ex.next_pc = pc;
    ex.halt    = halted;
    ex.ea      = sum[ADDR_W-1:0];
    wr         = 1'b0;
    if (!halted) begin
      unique case (op)
        OP_LUI:   begin wr = 1'b1; ex.val = imm; ex.next_pc = pc4; end
        OP_AUIPC: begin wr = 1'b1; ex.val = pci; ex.next_pc = pc4; end
        OP_JAL:   begin wr = 1'b1; ex.val = pc4; ex.next_pc = pci; end
        OP_JALR:  begin
          wr = 1'b1;
          ex.val = pc4;
          ex.next_pc = {sum[XLEN-1:1], 1'b0};
        end
        OP_BEQ:   ex.next_pc = (a == b) ? pci : pc4;
        OP_BNE:   ex.next_pc = (a != b) ? pci : pc4;
        OP_BLT:   ex.next_pc = ($signed(a) < $signed(b)) ? pci : pc4;
        OP_BGE:   ex.next_pc = ($signed(a) < $signed(b)) ? pc4 : pci;
        OP_BLTU:  ex.next_pc = (a < b) ? pci : pc4;
        OP_BGEU:  ex.next_pc = (a < b) ? pc4 : pci;
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
          wr = 1'b1;
          ex.is_load = 1'b1;
          ex.next_pc = pc4;
        end
        OP_SB:    begin
          ex.mem_wr = 1'b1;
          ex.mem_val = {{(XLEN-8){1'b0}}, b[7:0]};
          ex.next_pc = pc4;
        end
        OP_SH:    begin
          ex.mem_wr = 1'b1;
          ex.mem_val = {{(XLEN-16){1'b0}}, b[15:0]};
          ex.next_pc = pc4;
        end
        OP_SW:    begin ex.mem_wr = 1'b1; ex.mem_val = b; ex.next_pc = pc4; end
        OP_ADDI:  begin wr = 1'b1; ex.val = sum; ex.next_pc = pc4; end
        OP_SLTI:  begin
          wr = 1'b1;
          ex.val = {{(XLEN-1){1'b0}}, $signed(a) < $signed(imm)};
          ex.next_pc = pc4;
        end
        OP_SLTIU: begin
          wr = 1'b1;
          ex.val = {{(XLEN-1){1'b0}}, a < imm};
          ex.next_pc = pc4;
        end
        OP_XORI:  begin wr = 1'b1; ex.val = a ^ imm; ex.next_pc = pc4; end
        OP_ORI:   begin wr = 1'b1; ex.val = a | imm; ex.next_pc = pc4; end
        OP_ANDI:  begin wr = 1'b1; ex.val = a & imm; ex.next_pc = pc4; end
        OP_SLLI:  begin wr = 1'b1; ex.val = a << shi; ex.next_pc = pc4; end
        OP_SRLI:  begin wr = 1'b1; ex.val = a >> shi; ex.next_pc = pc4; end
        OP_SRAI:  begin
          wr = 1'b1;
          ex.val = $unsigned($signed(a) >>> shi);
          ex.next_pc = pc4;
        end
        OP_ADD:   begin wr = 1'b1; ex.val = a + b; ex.next_pc = pc4; end
        OP_SUB:   begin wr = 1'b1; ex.val = a - b; ex.next_pc = pc4; end
        OP_SLL:   begin wr = 1'b1; ex.val = a << shr; ex.next_pc = pc4; end
        OP_SLT:   begin
          wr = 1'b1;
          ex.val = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
          ex.next_pc = pc4;
        end
        OP_SLTU:  begin
          wr = 1'b1;
          ex.val = {{(XLEN-1){1'b0}}, a < b};
          ex.next_pc = pc4;
        end
        OP_XOR:   begin wr = 1'b1; ex.val = a ^ b; ex.next_pc = pc4; end
        OP_SRL:   begin wr = 1'b1; ex.val = a >> shr; ex.next_pc = pc4; end
        OP_SRA:   begin
          wr = 1'b1;
          ex.val = $unsigned($signed(a) >>> shr);
          ex.next_pc = pc4;
        end
        OP_OR:    begin wr = 1'b1; ex.val = a | b; ex.next_pc = pc4; end
        OP_AND:   begin wr = 1'b1; ex.val = a & b; ex.next_pc = pc4; end
        OP_HALT:  ex.halt = 1'b1;
        default:  ex.next_pc = pc;
      endcase
    end
    // x0 is never written
    ex.reg_wr = wr && (rd != '0);
  end

endmodule

/* src/rv32i_instruction_execute.sv */
// RV32I execute block: one decoded instruction per input item, one result per item.
// Input stream s_*: s_tdata carries operation, rd, rs1, rs2, immediate.
// Output stream m_*: one result item per input item with new PC, register write,
//   memory write and halt status.
// Config channel cfg_*: writing cfg_data loads the program counter; always ready.
//   Write it only while no item is in flight.
// Pipeline: input register (operands read from the register file here),
//   execute (PC, branch, ALU, store, load address), memory read, result.
//   m_tvalid follows the accepting edge through the input, memory and result
//   registers; one item per cycle sustained while m_tready stays high.
//   Register results, including load data, are forwarded from the memory
//   stage into execute, so dependent items follow back to back.
// Reset: PC, halt flag and pipeline clear; the data memory and register file
//   are then swept to zero, one cell per cycle through all MEM_DEPTH (1024)
//   addresses, during which s_tready stays low. Config writes are still taken.
// Stall: the whole pipeline holds while a result waits on m_tready low;
//   s_tready falls in the same cycle.
// Once a halt instruction has executed, later items produce the current PC,
//   no writes and halted set. Unknown operations leave all state untouched.
module rv32i_instruction_execute (
  input  logic                         clk,
  input  logic                         rst,
  // [5:0] operation, [10:6] dest_index, [15:11] first_source_index,
  // [20:16] second_source_index, [52:21] immediate, [55:53] zero
  input  logic [rvx_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [31:0] pc_after, [32] reg_write, [37:33] written_index,
  // [69:38] written_value, [70] mem_write, [80:71] mem_address,
  // [112:81] mem_value, [113] halted, [119:114] zero
  output logic [rvx_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [rvx_pkg::XLEN-1:0]     cfg_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready
);
  import rvx_pkg::*;

  // Pipeline advance: everything moves together unless the result is stuck.
  logic en;

  // Architectural state
  logic [XLEN-1:0] pc;
  logic            halted;

  // Reset sweep
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // Input register stage
  logic            ir_valid;
  op_t             ir_op;
  logic [REG_W-1:0] ir_rd;
  logic [REG_W-1:0] ir_rs1;
  logic [REG_W-1:0] ir_rs2;
  logic [XLEN-1:0] ir_imm;
  logic [XLEN-1:0] rf_a;
  logic [XLEN-1:0] rf_b;

  // Memory stage
  logic              mr_valid;
  op_t               mr_op;
  logic              mr_load;
  logic              mr_wr;
  logic [REG_W-1:0]  mr_rd;
  logic [XLEN-1:0]   mr_val;
  logic [XLEN-1:0]   mr_pc;
  logic              mr_mw;
  logic [ADDR_W-1:0] mr_maddr;
  logic [XLEN-1:0]   mr_mval;
  logic              mr_halted;
  logic [XLEN-1:0]   mr_value;
  logic [XLEN-1:0]   dmem_q;

  // Result stage
  logic              rr_valid;
  logic [XLEN-1:0]   rr_pc;
  logic              rr_wr;
  logic [REG_W-1:0]  rr_rd;
  logic [XLEN-1:0]   rr_val;
  logic              rr_mw;
  logic [ADDR_W-1:0] rr_maddr;
  logic [XLEN-1:0]   rr_mval;
  logic              rr_halted;

  // Execute
  logic [XLEN-1:0] op_a;
  logic [XLEN-1:0] op_b;
  ex_t             ex;
  logic            ex_fire;

  // Storage ports
  logic              rf_we;
  logic [REG_W-1:0]  rf_waddr;
  logic [XLEN-1:0]   rf_wdata;
  logic              dm_we;
  logic [ADDR_W-1:0] dm_waddr;
  logic [XLEN-1:0]   dm_wdata;

  assign en        = !rr_valid || m_tready;
  assign s_tready  = en && !clearing;
  assign cfg_ready = 1'b1;
  assign ex_fire   = en && ir_valid;

  // ---------------- reset sweep ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------- register file ----------------
  always_comb begin
    if (clearing) begin
      rf_we    = (clr_addr[ADDR_W-1:REG_W] == '0);
      rf_waddr = clr_addr[REG_W-1:0];
      rf_wdata = '0;
    end else begin
      rf_we    = en && mr_valid && mr_wr;
      rf_waddr = mr_rd;
      rf_wdata = mr_value;
    end
  end

  rvx_regfile u_regfile (
    .clk     (clk),
    .en      (en),
    .raddr_a (s_tdata[15:11]),
    .raddr_b (s_tdata[20:16]),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  // ---------------- input register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (en) begin
      ir_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ir_op  <= op_t'(s_tdata[5:0]);
      ir_rd  <= s_tdata[10:6];
      ir_rs1 <= s_tdata[15:11];
      ir_rs2 <= s_tdata[20:16];
      ir_imm <= s_tdata[52:21];
    end
  end

  // ---------------- execute ----------------
  // Forward the older item still in the memory stage (not yet in the file).
  assign mr_value = mr_load ? load_ext(mr_op, dmem_q) : mr_val;
  assign op_a = (mr_valid && mr_wr && mr_rd == ir_rs1) ? mr_value : rf_a;
  assign op_b = (mr_valid && mr_wr && mr_rd == ir_rs2) ? mr_value : rf_b;

  rvx_exec u_exec (
    .op     (ir_op),
    .rd     (ir_rd),
    .a      (op_a),
    .b      (op_b),
    .imm    (ir_imm),
    .pc     (pc),
    .halted (halted),
    .ex     (ex)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= '0;
      halted <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pc <= cfg_data;
      end else if (ex_fire) begin
        pc <= ex.next_pc;
      end
      if (ex_fire) begin
        halted <= ex.halt;
      end
    end
  end

  // ---------------- data memory ----------------
  assign dm_we    = clearing || (ex_fire && ex.mem_wr);
  assign dm_waddr = clearing ? clr_addr : ex.ea;
  assign dm_wdata = clearing ? '0 : ex.mem_val;

  rvx_dmem u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (en),
    .raddr (ex.ea),
    .rdata (dmem_q)
  );

  // ---------------- memory stage ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mr_valid <= 1'b0;
    end else if (en) begin
      mr_valid <= ir_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mr_op     <= ir_op;
      mr_load   <= ex.is_load;
      mr_wr     <= ex.reg_wr;
      mr_rd     <= ex.reg_wr ? ir_rd : '0;
      mr_val    <= ex.val;
      mr_pc     <= ex.next_pc;
      mr_mw     <= ex.mem_wr;
      mr_maddr  <= ex.mem_wr ? ex.ea : '0;
      mr_mval   <= ex.mem_val;
      mr_halted <= ex.halt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rr_valid <= 1'b0;
    end else if (en) begin
      rr_valid <= mr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr_pc     <= mr_pc;
      rr_wr     <= mr_wr;
      rr_rd     <= mr_rd;
      rr_val    <= mr_wr ? mr_value : '0;
      rr_mw     <= mr_mw;
      rr_maddr  <= mr_maddr;
      rr_mval   <= mr_mval;
      rr_halted <= mr_halted;
    end
  end

  assign m_tvalid = rr_valid;
  assign m_tdata  = {6'b0, rr_halted, rr_mval, rr_maddr, rr_mw,
                     rr_val, rr_rd, rr_wr, rr_pc};

  // ---------------- assertions ----------------
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("item accepted during memory sweep");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag dropped");

  a_halted_inert: assert property (@(posedge clk) disable iff (rst)
    ir_valid && halted |-> !ex.reg_wr && !ex.mem_wr && ex.next_pc == pc)
    else $error("halted block changed state");

  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    rf_we && !clearing |-> rf_waddr != '0)
    else $error("write to x0");

  a_clean_result: assert property (@(posedge clk) disable iff (rst)
    rr_valid && !rr_mw |-> rr_maddr == '0 && rr_mval == '0)
    else $error("memory fields set without a memory write");

endmodule

/* tb/rv32i_instruction_execute_tb.sv */
module rv32i_instruction_execute_tb;
  import rvx_pkg::*;

  localparam int CYCLE_LIMIT    = 800_000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 10;
  localparam int PHASE_ITEMS    = 400;

  // Input item, operation in the low bits (matches s_tdata layout).
  typedef struct packed {
    logic [XLEN-1:0]  imm;
    logic [REG_W-1:0] rs2;
    logic [REG_W-1:0] rs1;
    logic [REG_W-1:0] rd;
    logic [OP_W-1:0]  op;
  } instr_t;

  // Result item, pc_after in the low bits (matches m_tdata layout).
  typedef struct packed {
    logic              halted;
    logic [XLEN-1:0]   mem_value;
    logic [ADDR_W-1:0] mem_address;
    logic              mem_write;
    logic [XLEN-1:0]   written_value;
    logic [REG_W-1:0]  written_index;
    logic              reg_write;
    logic [XLEN-1:0]   pc_after;
  } exec_result_t;

  localparam int RES_W = $bits(exec_result_t);

  // Architectural shadow of the block plus the queue of results owed.
  class exec_scoreboard;
    logic [XLEN-1:0] regs [32];
    logic [XLEN-1:0] mem [MEM_DEPTH];
    logic [XLEN-1:0] pc;
    bit              halted;
    exec_result_t    pending [$];
    int mismatches, noted, checked, loads, stores, taken_branches, unknown_ops, start_writes;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc = '0;
      halted = 1'b0;
    endfunction

    task flag_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Start address write only moves the PC.
    function void load_start(input logic [XLEN-1:0] addr);
      pc = addr;
      start_writes++;
    endfunction

    function void note_instruction(input instr_t ins);
      exec_result_t      r;
      logic [XLEN-1:0]   a, b, imm, ea, d, val, npc, mval;
      logic [ADDR_W-1:0] slot;
      bit                branch, store, taken;
      a      = regs[ins.rs1];
      b      = regs[ins.rs2];
      imm    = ins.imm;
      ea     = a + imm;
      slot   = ea[ADDR_W-1:0];
      d      = mem[slot];
      npc    = pc + 32'd4;
      val    = '0;
      taken  = 1'b0;
      r      = '0;
      branch = (ins.op >= OP_BEQ) && (ins.op <= OP_BGEU);
      store  = (ins.op >= OP_SB) && (ins.op <= OP_SW);
      noted++;
      if (halted || ins.op > OP_HALT) begin
        // frozen: nothing moves, PC included
        npc = pc;
        if (ins.op > OP_HALT) unknown_ops++;
      end else if (ins.op == OP_HALT) begin
        halted = 1'b1;
        npc = pc;
      end else if (branch) begin
        case (ins.op)
          OP_BEQ:  taken = (a == b);
          OP_BNE:  taken = (a != b);
          OP_BLT:  taken = ($signed(a) < $signed(b));
          OP_BGE:  taken = !($signed(a) < $signed(b));
          OP_BLTU: taken = (a < b);
          default: taken = (a >= b);
        endcase
        if (taken) begin
          npc = pc + imm;
          taken_branches++;
        end
      end else if (store) begin
        mval = (ins.op == OP_SB) ? {24'd0, b[7:0]} :
               (ins.op == OP_SH) ? {16'd0, b[15:0]} : b;
        mem[slot] = mval;
        r.mem_write = 1'b1;
        r.mem_address = slot;
        r.mem_value = mval;
        stores++;
      end else begin
        case (ins.op)
          OP_LUI:   val = imm;
          OP_AUIPC: val = pc + imm;
          OP_JAL: begin
            val = pc + 32'd4;
            npc = pc + imm;
          end
          OP_JALR: begin
            val = pc + 32'd4;
            npc = ea & ~32'd1;   // rs1 already read above
          end
          OP_LB:    val = {{24{d[7]}}, d[7:0]};
          OP_LH:    val = {{16{d[15]}}, d[15:0]};
          OP_LW:    val = d;
          OP_LBU:   val = {24'd0, d[7:0]};
          OP_LHU:   val = {16'd0, d[15:0]};
          OP_ADDI:  val = a + imm;
          OP_SLTI:  val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
          OP_SLTIU: val = (a < imm) ? 32'd1 : 32'd0;
          OP_XORI:  val = a ^ imm;
          OP_ORI:   val = a | imm;
          OP_ANDI:  val = a & imm;
          OP_SLLI:  val = a << imm[4:0];
          OP_SRLI:  val = a >> imm[4:0];
          OP_SRAI:  val = $unsigned($signed(a) >>> imm[4:0]);
          OP_ADD:   val = a + b;
          OP_SUB:   val = a - b;
          OP_SLL:   val = a << b[4:0];
          OP_SLT:   val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          OP_SLTU:  val = (a < b) ? 32'd1 : 32'd0;
          OP_XOR:   val = a ^ b;
          OP_SRL:   val = a >> b[4:0];
          OP_SRA:   val = $unsigned($signed(a) >>> b[4:0]);
          OP_OR:    val = a | b;
          default:  val = a & b;
        endcase
        if (ins.op >= OP_LB && ins.op <= OP_LHU) loads++;
        if (ins.rd != '0) begin
          regs[ins.rd] = val;
          r.reg_write = 1'b1;
          r.written_index = ins.rd;
          r.written_value = val;
        end
      end
      pc = npc;
      r.pc_after = npc;
      r.halted = halted;
      pending = {pending, r};
    endfunction

    task compare_field(input string name, input logic [XLEN-1:0] got_v, exp_v);
      if (got_v !== exp_v)
        flag_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                checked, name, got_v, exp_v));
    endtask

    task check_result(input logic [M_DATA_W-1:0] raw);
      exec_result_t got, want;
      got = raw[RES_W-1:0];
      if (raw[M_DATA_W-1:RES_W] !== '0)
        flag_mismatch($sformatf("result %0d: nonzero padding %h", checked,
                                raw[M_DATA_W-1:RES_W]));
      if (pending.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing outstanding", checked));
        checked++;
        return;
      end
      want = pending.pop_front();
      compare_field("pc_after", got.pc_after, want.pc_after);
      compare_field("reg_write", XLEN'(got.reg_write), XLEN'(want.reg_write));
      compare_field("written_index", XLEN'(got.written_index),
                    XLEN'(want.written_index));
      compare_field("written_value", got.written_value, want.written_value);
      compare_field("mem_write", XLEN'(got.mem_write), XLEN'(want.mem_write));
      compare_field("mem_address", XLEN'(got.mem_address), XLEN'(want.mem_address));
      compare_field("mem_value", got.mem_value, want.mem_value);
      compare_field("halted", XLEN'(got.halted), XLEN'(want.halted));
      checked++;
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic [S_DATA_W-1:0]   s_tdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [XLEN-1:0]       cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;

  exec_scoreboard sb;
  bit  squeeze_go, squeeze_active, squeeze_done;
  bit  tx_steady, rx_steady;
  int  tx_count, rx_ticks, cycles;

  rv32i_instruction_execute dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic instr_t mk(input logic [OP_W-1:0] op, input int rd, rs1, rs2,
                                input logic [XLEN-1:0] imm);
    instr_t ins;
    ins.op  = op;
    ins.rd  = rd[REG_W-1:0];
    ins.rs1 = rs1[REG_W-1:0];
    ins.rs2 = rs2[REG_W-1:0];
    ins.imm = imm;
    return ins;
  endfunction

  // Random instruction, biased toward memory traffic in a small hot region
  // so that loads mostly see cells written earlier.
  function automatic instr_t random_instruction();
    instr_t            ins;
    int                pick, style;
    logic [XLEN-1:0]   hi;
    logic [ADDR_W-1:0] slot;
    pick = $urandom_range(0, 99);
    style = $urandom_range(0, 9);
    ins.rd  = ($urandom_range(0, 9) == 0) ? '0 : REG_W'($urandom_range(1, 31));
    ins.rs1 = REG_W'($urandom_range(0, 31));
    ins.rs2 = ($urandom_range(0, 3) == 0) ? ins.rs1 : REG_W'($urandom_range(0, 31));
    if (pick < 3)       ins.op = OP_W'($urandom_range(OP_HALT + 1, 63));
    else if (pick < 18) ins.op = OP_W'($urandom_range(OP_SB, OP_SW));
    else if (pick < 33) ins.op = OP_W'($urandom_range(OP_LB, OP_LHU));
    else if (pick < 43) ins.op = OP_W'($urandom_range(OP_BEQ, OP_BGEU));
    else if (pick < 50) ins.op = OP_W'($urandom_range(OP_JAL, OP_JALR));
    else                ins.op = OP_W'($urandom_range(OP_LUI, OP_AND));
    case (style)
      0, 1, 2, 3: ins.imm = $urandom;
      4, 5:       ins.imm = XLEN'($urandom_range(0, 127)) - 32'd64;
      6: begin
        case ($urandom_range(0, 4))
          0:       ins.imm = 32'h0000_0000;
          1:       ins.imm = 32'h0000_0001;
          2:       ins.imm = 32'hFFFF_FFFF;
          3:       ins.imm = 32'h7FFF_FFFF;
          default: ins.imm = 32'h8000_0000;
        endcase
      end
      default:    ins.imm = XLEN'($urandom_range(0, 31));
    endcase
    if (ins.op >= OP_LB && ins.op <= OP_SW && $urandom_range(0, 9) < 7) begin
      hi = $urandom;
      slot = ADDR_W'($urandom_range(0, 63));
      ins.imm = {hi[XLEN-1:ADDR_W], slot} - sb.regs[ins.rs1];
    end
    return ins;
  endfunction

  // Offer one item after a random gap; hold it until taken.
  task automatic issue(input instr_t ins);
    int idle;
    if (tx_count % 64 == 0) tx_steady = ($urandom_range(0, 3) == 0);
    tx_count++;
    idle = (squeeze_active || tx_steady) ? 0 : pause_len();
    if (idle > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'(ins);
    do @(posedge clk); while (!s_tready);
    sb.note_instruction(ins);
  endtask

  // Stop offering and let every owed result come back, plus pipeline slack.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_start_address(input logic [XLEN-1:0] addr);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    sb.load_start(addr);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output side: random back-pressure, steady stretches, and one long hold
  // while the sender keeps pushing so the pipeline backs up into s_tready.
  initial begin
    int stall;
    stall = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_ticks++;
      if (rx_ticks % 128 == 0) rx_steady = ($urandom_range(0, 2) == 0);
      if (squeeze_go && !squeeze_done) begin
        squeeze_active = 1'b1;
        m_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
        m_tready <= 1'b1;
        squeeze_active = 1'b0;
        squeeze_done = 1'b1;
      end else begin
        if (stall == 0 && !rx_steady && $urandom_range(0, 4) == 0) stall = pause_len();
        m_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Watchdog; budget covers the post-reset clear sweep and worst-case gaps.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.pending.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [XLEN-1:0] starts [5];
    starts[0] = 32'hFFFF_FFFC;
    starts[1] = 32'h8000_0000;
    starts[2] = 32'hFFFF_FFFF;
    starts[3] = $urandom;
    starts[4] = 32'h0000_0000;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_start_address(32'h0000_0100);

    // Directed: field extremes and every operation but halt at least once.
    issue(mk(OP_LUI,   1, 0, 0, 32'h8000_0000));
    issue(mk(OP_LUI,   2, 0, 0, 32'h7FFF_FFFF));
    issue(mk(OP_ADDI,  3, 0, 0, 32'hFFFF_FFFF));
    issue(mk(OP_ADDI,  0, 3, 0, 32'd5));          // x0 write dropped
    issue(mk(OP_AUIPC, 4, 0, 0, 32'h0000_1000));
    issue(mk(OP_SW,    0, 0, 3, 32'd1023));
    issue(mk(OP_SB,    0, 0, 3, 32'd1));          // whole cell <- 0xFF
    issue(mk(OP_SH,    0, 0, 3, 32'd2));
    issue(mk(OP_LB,    5, 0, 0, 32'd1));          // sign-extends
    issue(mk(OP_LBU,   6, 0, 0, 32'd1));
    issue(mk(OP_LH,    7, 0, 0, 32'd2));
    issue(mk(OP_LHU,   8, 0, 0, 32'd2));
    issue(mk(OP_LW,    9, 3, 0, 32'd0));          // address wraps to top cell
    issue(mk(OP_SLTI, 10, 1, 0, 32'd0));
    issue(mk(OP_SLTIU, 11, 1, 0, 32'hFFFF_FFFF));
    issue(mk(OP_XORI, 12, 2, 0, 32'hFFFF_FFFF));
    issue(mk(OP_ORI,  13, 1, 0, 32'd1));
    issue(mk(OP_ANDI, 14, 3, 0, 32'h8000_0000));
    issue(mk(OP_SLLI, 15, 3, 0, 32'd33));         // shift uses low 5 bits
    issue(mk(OP_SRLI, 16, 1, 0, 32'd31));
    issue(mk(OP_SRAI, 17, 1, 0, 32'hFFFF_FFFF));
    issue(mk(OP_ADD,  18, 1, 2, 32'd0));
    issue(mk(OP_SUB,  19, 0, 1, 32'd0));
    issue(mk(OP_SLL,  20, 3, 3, 32'd0));
    issue(mk(OP_SLT,  21, 1, 2, 32'd0));
    issue(mk(OP_SLTU, 22, 1, 2, 32'd0));
    issue(mk(OP_XOR,  23, 1, 3, 32'd0));
    issue(mk(OP_SRL,  24, 1, 3, 32'd0));
    issue(mk(OP_SRA,  25, 1, 3, 32'd0));
    issue(mk(OP_OR,   26, 1, 2, 32'd0));
    issue(mk(OP_AND,  27, 3, 2, 32'd0));
    issue(mk(OP_BEQ,   0, 1, 1, 32'hFFFF_FFF0));
    issue(mk(OP_BNE,   0, 1, 1, 32'd64));
    issue(mk(OP_BLT,   0, 1, 2, 32'd8));
    issue(mk(OP_BGE,   0, 1, 2, 32'd8));
    issue(mk(OP_BLTU,  0, 1, 2, 32'd8));
    issue(mk(OP_BGEU,  0, 3, 0, 32'h7FFF_FFFC));
    issue(mk(OP_JAL,  28, 0, 0, 32'hFFFF_FFF8));
    issue(mk(OP_JALR,  3, 3, 0, 32'd0));          // rd == rs1, odd target
    issue(mk(OP_JALR, 29, 0, 0, 32'hFFFF_FFFF));
    issue(mk(6'd63,   30, 1, 2, 32'hFFFF_FFFF));  // unknown op: no change
    drain();

    // Random phases, each from a different start address.
    for (int p = 0; p < 5; p++) begin
      load_start_address(starts[p]);
      if (p == 1) squeeze_go = 1'b1;
      repeat (PHASE_ITEMS) issue(random_instruction());
      drain();
    end

    // Halt, then confirm a halted block ignores everything.
    issue(mk(OP_HALT, 0, 0, 0, 32'd0));
    issue(mk(OP_SW,   0, 0, 3, 32'd5));
    issue(mk(OP_LUI,  7, 0, 0, 32'h1234_5000));
    issue(mk(OP_JAL,  1, 0, 0, 32'd16));
    issue(mk(OP_HALT, 0, 0, 0, 32'd0));
    repeat (6) issue(random_instruction());
    drain();

    if (sb.pending.size() != 0)
      sb.flag_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
    $display("covered %0d instructions: %0d loads, %0d stores, %0d taken branches,",
             sb.noted, sb.loads, sb.stores, sb.taken_branches);
    $display("  %0d unknown ops; checked %0d results over %0d start addresses",
             sb.unknown_ops, sb.checked, sb.start_writes);
    $display("  including a %0d-cycle output hold", SQUEEZE_CYCLES);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rvx_pkg.sv
src/rvx_regfile.sv
src/rvx_dmem.sv
src/rvx_exec.sv
src/rv32i_instruction_execute.sv
tb/rv32i_instruction_execute_tb.sv
